>>> hw/rtl/swept_circle_hit_test_macros.svh
// Assertion macros for the swept circle hit test.
`ifndef SWEPT_CIRCLE_HIT_TEST_MACROS_SVH
`define SWEPT_CIRCLE_HIT_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define SCH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies an expectation in the next cycle.
`define SCH_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);
`else
`define SCH_ASSERT(label, prop, msg)
`define SCH_ASSERT_NEXT(label, cond, conseq, msg)
`endif
`endif

>>> hw/rtl/sch_pkg.sv
// Types, constants and the microcode table of the swept circle hit test.
package sch_pkg;

  // Quarter-wave sine polynomial coefficients, result in Q14.
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [14:0] SIN_B = 15'd10512;
  localparam logic [17:0] SIN_C = 18'd1160;

  // Heading resolution; low heading bits are cleared below 12 bits.
  localparam int          ANGLE_BITS = 12;
  localparam int          ANG_DROP   = (ANGLE_BITS < 12) ? 12 - ANGLE_BITS : 0;
  localparam logic [11:0] ANG_MASK   = 12'(12'hFFF << ANG_DROP);
  localparam logic [11:0] QUARTER    = 12'd1024;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    L_NOP, L_LOAD, L_Z2, L_PB, L_PA, L_PT, L_SCALE, L_OFFS, L_SQ
  } lane_op_t;

  typedef enum logic [2:0] {
    S_NOP, S_LOAD, S_INIT, S_CMP, S_STEP, S_DONE
  } seq_op_t;

  typedef enum logic [2:0] {
    J_NONE, J_NO_IN, J_SKIP, J_HIT_OR_SLOW, J_LOOP_END, J_MISS, J_OUT_BUSY
  } jump_t;

  typedef struct packed {
    lane_op_t          lane_op;
    seq_op_t           seq_op;
    jump_t             jump;
    logic [PC_W-1:0]   target;
    logic              last;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_INIT  = 4'd1;
  localparam logic [PC_W-1:0] PC_Z2    = 4'd2;
  localparam logic [PC_W-1:0] PC_PB    = 4'd3;
  localparam logic [PC_W-1:0] PC_PA    = 4'd4;
  localparam logic [PC_W-1:0] PC_PT    = 4'd5;
  localparam logic [PC_W-1:0] PC_LOOP  = 4'd6;
  localparam logic [PC_W-1:0] PC_OFFS  = 4'd7;
  localparam logic [PC_W-1:0] PC_SQ    = 4'd8;
  localparam logic [PC_W-1:0] PC_CMP   = 4'd9;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd10;

  // A taken jump goes to the target, otherwise the program falls through,
  // or returns to idle after the last word.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{L_NOP, S_NOP, J_NONE, PC_IDLE, 1'b0};
    unique case (pc)
      PC_IDLE: c = '{L_LOAD,  S_LOAD, J_NO_IN,       PC_IDLE, 1'b0};
      PC_INIT: c = '{L_SQ,    S_INIT, J_SKIP,        PC_DONE, 1'b0};
      PC_Z2:   c = '{L_Z2,    S_CMP,  J_HIT_OR_SLOW, PC_DONE, 1'b0};
      PC_PB:   c = '{L_PB,    S_NOP,  J_NONE,        PC_IDLE, 1'b0};
      PC_PA:   c = '{L_PA,    S_NOP,  J_NONE,        PC_IDLE, 1'b0};
      PC_PT:   c = '{L_PT,    S_NOP,  J_NONE,        PC_IDLE, 1'b0};
      PC_LOOP: c = '{L_SCALE, S_STEP, J_LOOP_END,    PC_DONE, 1'b0};
      PC_OFFS: c = '{L_OFFS,  S_NOP,  J_NONE,        PC_IDLE, 1'b0};
      PC_SQ:   c = '{L_SQ,    S_NOP,  J_NONE,        PC_IDLE, 1'b0};
      PC_CMP:  c = '{L_NOP,   S_CMP,  J_MISS,        PC_LOOP, 1'b0};
      PC_DONE: c = '{L_NOP,   S_DONE, J_OUT_BUSY,    PC_DONE, 1'b1};
      default: c.last = 1'b1;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/sch_lane.sv
// One axis of the datapath: trig polynomial, path offset and squared distance.
module sch_lane (
  input  logic               clk,
  input  sch_pkg::lane_op_t  op,
  input  logic signed [15:0] obj_pos,
  input  logic signed [15:0] tgt_pos,
  input  logic [11:0]        angle,
  input  logic signed [12:0] step_ofs,
  output logic [32:0]        sq
);

  logic signed [16:0] diff_r;
  logic signed [17:0] pos_r;
  logic [10:0]        t_r;
  logic               neg_r;
  logic [10:0]        z_r;
  logic [14:0]        y_r;
  logic signed [15:0] trig_r;
  logic signed [27:0] prod_r;
  logic [32:0]        sq_r;

  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] prod;
  logic [27:0]        mag;
  logic [27:0]        rnd;
  logic signed [17:0] offs;
  logic [14:0]        trig_mag;

  // One shared multiplier; the microcode picks its operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      sch_pkg::L_Z2: begin
        mul_a = $signed({7'b0, t_r});
        mul_b = $signed({7'b0, t_r});
      end
      sch_pkg::L_PB: begin
        mul_a = $signed(sch_pkg::SIN_C);
        mul_b = $signed({7'b0, z_r});
      end
      sch_pkg::L_PA: begin
        mul_a = $signed({3'b0, y_r});
        mul_b = $signed({7'b0, z_r});
      end
      sch_pkg::L_PT: begin
        mul_a = $signed({3'b0, y_r});
        mul_b = $signed({7'b0, t_r});
      end
      sch_pkg::L_SCALE: begin
        mul_a = 18'(trig_r);
        mul_b = 18'(step_ofs);
      end
      sch_pkg::L_SQ: begin
        mul_a = pos_r;
        mul_b = pos_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign trig_mag = prod[24:10];

  // Offset rounds half away from zero: round the magnitude, then restore the sign.
  assign mag  = prod_r[27] ? 28'(-prod_r) : 28'(prod_r);
  assign rnd  = mag + 28'd8192;
  assign offs = prod_r[27] ? -$signed({5'b0, rnd[26:14]}) : $signed({5'b0, rnd[26:14]});

  always_ff @(posedge clk) begin
    unique case (op)
      sch_pkg::L_LOAD: begin
        diff_r <= 17'(obj_pos) - 17'(tgt_pos);
        pos_r  <= 18'(obj_pos) - 18'(tgt_pos);
        t_r    <= angle[10] ? 11'(11'd1024 - {1'b0, angle[9:0]}) : {1'b0, angle[9:0]};
        neg_r  <= angle[11];
      end
      sch_pkg::L_Z2:    z_r    <= prod[20:10];
      sch_pkg::L_PB:    y_r    <= sch_pkg::SIN_B - {4'b0, prod[20:10]};
      sch_pkg::L_PA:    y_r    <= sch_pkg::SIN_A - {1'b0, prod[23:10]};
      sch_pkg::L_PT:    trig_r <= neg_r ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});
      sch_pkg::L_SCALE: prod_r <= prod[27:0];
      sch_pkg::L_OFFS:  pos_r  <= 18'(diff_r) + offs;
      sch_pkg::L_SQ:    sq_r   <= prod[32:0];
      default: ;
    endcase
  end

  assign sq = sq_r;

endmodule

>>> hw/rtl/swept_circle_hit_test.sv
// An item goes from the init step straight to the done step when its age or radius
// sum is zero, and from the distance test when the circles overlap at the current
// position or the speed does not exceed the radius sum. Otherwise n path samples
// are tried (at most MAX_STEPS) until a sample hits or every sample misses; the
// done step also holds for as long as the previous result waits untaken. A microcode
// sequencer steps two axis lanes, each with one shared multiplier: six steps load the
// item, test the current distance and evaluate sine and cosine, then every path
// sample takes four steps (scale, offset, square, compare). The next item is
// accepted once the result sits in the output register, even while that result is
// not yet taken.
module swept_circle_hit_test #(
  parameter int MAX_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obj_x, obj_y, obj_radius, heading, speed, age, target_x, target_y, zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit, zero pad
  output logic [7:0]   out_tdata,
  input  logic         cfg_wr_en,
  input  logic [11:0]  cfg_wr_data
);

  `include "swept_circle_hit_test_macros.svh"

  localparam int KW = $clog2(MAX_STEPS + 1);

  logic [sch_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [11:0]   target_radius_r;
  logic [12:0]   rsum_r;
  logic [11:0]   spd_r;
  logic          age_zero_r;
  logic [25:0]   rsq_r;
  logic [13:0]   kr_r;
  logic [KW-1:0] k_r;
  logic          hit_r;
  logic          out_valid_r;
  logic          out_hit_r;

  sch_pkg::ctrl_t    ctrl;
  sch_pkg::lane_op_t lane_op;
  logic              accept;
  logic              take;
  logic              lt;
  logic              loop_end;
  logic              out_busy;
  logic [11:0]       ang_sin;
  logic [11:0]       ang_cos;
  logic signed [12:0] step_ofs;
  logic [32:0]       sq_x;
  logic [32:0]       sq_y;

  logic signed [15:0] in_obj_x;
  logic signed [15:0] in_obj_y;
  logic [11:0]        in_obj_radius;
  logic [11:0]        in_heading;
  logic [11:0]        in_speed;
  logic [15:0]        in_age;
  logic signed [15:0] in_target_x;
  logic signed [15:0] in_target_y;

  assign in_obj_x      = $signed(in_tdata[15:0]);
  assign in_obj_y      = $signed(in_tdata[31:16]);
  assign in_obj_radius = in_tdata[43:32];
  assign in_heading    = in_tdata[55:44];
  assign in_speed      = in_tdata[67:56];
  assign in_age        = in_tdata[83:68];
  assign in_target_x   = $signed(in_tdata[99:84]);
  assign in_target_y   = $signed(in_tdata[115:100]);

  assign ctrl      = sch_pkg::ucode(pc_r);
  assign in_tready = (pc_r == sch_pkg::PC_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign lane_op   = (ctrl.lane_op == sch_pkg::L_LOAD && !accept) ? sch_pkg::L_NOP
                                                                  : ctrl.lane_op;

  assign ang_sin = in_heading & sch_pkg::ANG_MASK;
  assign ang_cos = ang_sin + sch_pkg::QUARTER;

  // Sample offset along the heading; negative while samples remain.
  assign step_ofs = $signed(13'(kr_r - {2'b00, spd_r}));

  assign lt       = ({1'b0, sq_x} + {1'b0, sq_y}) < {8'b0, rsq_r};
  assign loop_end = (k_r >= KW'(MAX_STEPS)) || (kr_r >= {2'b00, spd_r});
  assign out_busy = out_valid_r && !out_tready;

  sch_lane u_lane_x (
    .clk      (clk),
    .op       (lane_op),
    .obj_pos  (in_obj_x),
    .tgt_pos  (in_target_x),
    .angle    (ang_cos),
    .step_ofs (step_ofs),
    .sq       (sq_x)
  );

  sch_lane u_lane_y (
    .clk      (clk),
    .op       (lane_op),
    .obj_pos  (in_obj_y),
    .tgt_pos  (in_target_y),
    .angle    (ang_sin),
    .step_ofs (step_ofs),
    .sq       (sq_y)
  );

  always_comb begin
    unique case (ctrl.jump)
      sch_pkg::J_NO_IN:       take = !accept;
      sch_pkg::J_SKIP:        take = age_zero_r || (rsum_r == 13'd0);
      sch_pkg::J_HIT_OR_SLOW: take = lt || ({1'b0, spd_r} <= rsum_r);
      sch_pkg::J_LOOP_END:    take = loop_end;
      sch_pkg::J_MISS:        take = !lt;
      sch_pkg::J_OUT_BUSY:    take = out_busy;
      default:                take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.last) begin
      pc_nxt = sch_pkg::PC_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r            <= sch_pkg::PC_IDLE;
      target_radius_r <= 12'd64;
      out_valid_r     <= 1'b0;
      k_r             <= '0;
      hit_r           <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr_en) begin
        target_radius_r <= cfg_wr_data;
      end
      if (ctrl.seq_op == sch_pkg::S_DONE && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctrl.seq_op)
        sch_pkg::S_LOAD: if (accept) hit_r <= 1'b0;
        sch_pkg::S_INIT: k_r <= '0;
        sch_pkg::S_CMP:  hit_r <= lt;
        sch_pkg::S_STEP: if (!loop_end) k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.seq_op)
      sch_pkg::S_LOAD: begin
        if (accept) begin
          rsum_r     <= {1'b0, in_obj_radius} + {1'b0, target_radius_r};
          spd_r      <= in_speed;
          age_zero_r <= (in_age == 16'd0);
        end
      end
      sch_pkg::S_INIT: begin
        rsq_r <= 26'(rsum_r) * 26'(rsum_r);
        kr_r  <= '0;
      end
      sch_pkg::S_STEP: if (!loop_end) kr_r <= kr_r + {1'b0, rsum_r};
      sch_pkg::S_DONE: if (!out_busy) out_hit_r <= hit_r;
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_hit_r};

  `SCH_ASSERT(a_out_from_done, $rose(out_tvalid) |-> $past(pc_r == sch_pkg::PC_DONE), "result appeared outside the done step")
  `SCH_ASSERT_NEXT(a_done_loads_out, ctrl.seq_op == sch_pkg::S_DONE && !out_busy, out_valid_r && out_hit_r == $past(hit_r), "done step did not load the result")
  `SCH_ASSERT(a_k_bound, k_r <= KW'(MAX_STEPS), "sample counter ran past its limit")
  `SCH_ASSERT(a_dist_negative, (ctrl.lane_op == sch_pkg::L_SCALE && !loop_end) |-> step_ofs[12], "path sample offset is not behind the position")

endmodule
